[rtl/core/rgb_linear_fade_generator_defines.svh]
// ----------------------------------------------------------------------------
// RGB linear fade generator assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LINEAR_FADE_GENERATOR_DEFINES_SVH
`define RGB_LINEAR_FADE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLFG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rlfg_pkg.sv]
// ----------------------------------------------------------------------------
// RGB linear fade generator package
// Widths, constants and codes shared by the fade generator modules.
// ----------------------------------------------------------------------------
package rlfg_pkg;

    localparam int COLOR_W       = 8;
    localparam int STEPS_W       = 7;
    localparam int DUR_W         = 15;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int MAX_STEPS_DEF = 64;

    localparam int NCHAN  = 3;
    localparam int CHAN_W = 2;

    // Shared divider: 15-bit dividend, 7-bit divisor.
    localparam int NUM_W     = 15;
    localparam int DEN_W     = 7;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam int PCT = 100;
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

    // floor(p / 100) == (p * RECIP_100) >> RECIP_SH for every p below 1864135.
    localparam int RECIP_W   = 21;
    localparam int RECIP_100 = 1342178;
    localparam int RECIP_SH  = 27;
    localparam int Q_W       = 10;

    // Divider jobs: one per color channel, then the hold time.
    localparam logic [CHAN_W-1:0] SUB_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] SUB_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] SUB_BLUE  = 2'd2;
    localparam logic [CHAN_W-1:0] SUB_HOLD  = 2'd3;

    localparam logic [ADDR_W-1:0] REG_POLARITY = 3'd0;

endpackage

[rtl/core/rlfg_div.sv]
// ----------------------------------------------------------------------------
// RGB linear fade generator divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlfg_div
    import rlfg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = (trial >= {1'b0, denom});
    assign trial_sub = trial - {1'b0, denom};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= numer;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/rgb_linear_fade_generator.sv]
// ----------------------------------------------------------------------------
// RGB linear fade generator
// Turns one fade request into a run of per-step RGB drive values.
// ----------------------------------------------------------------------------
// Each request fades from the kept current color to the target color in
// step_count steps (zero counts as one, counts above MAX_STEPS saturate) and
// yields one result per step, the last carrying the exact target and
// last_step. A request first runs four divisions by the step count on one
// shared bit-serial divider, and each step then passes through the MUL,
// RECIP and FIN states for each channel on the shared multiply path and
// then the EMIT state. No new request is taken until the last step has
// been handed to the output register.
module rgb_linear_fade_generator
    import rlfg_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COLOR_W-1:0] target_red,
    input  logic [COLOR_W-1:0] target_green,
    input  logic [COLOR_W-1:0] target_blue,
    input  logic [STEPS_W-1:0] step_count,
    input  logic [DUR_W-1:0]   duration_ms,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [COLOR_W-1:0] red_drive,
    output logic [COLOR_W-1:0] green_drive,
    output logic [COLOR_W-1:0] blue_drive,
    output logic [DUR_W-1:0]   hold_ms,
    output logic               last_step
);

`include "rgb_linear_fade_generator_defines.svh"

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int PROD_W = NUM_W + STEP_W;
    localparam int QM_W   = PROD_W + RECIP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DSTART = 3'd1;
    localparam logic [2:0] S_DWAIT  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_RECIP  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]         state_reg;
    logic [CHAN_W-1:0]  sub_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [STEP_W-1:0]  idx_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic               anode_reg;
    logic               out_valid_reg;

    logic [COLOR_W-1:0] cur_reg    [NCHAN];
    logic [COLOR_W-1:0] tgt_reg    [NCHAN];
    logic [COLOR_W-1:0] absdiff_reg[NCHAN];
    logic               neg_reg    [NCHAN];
    logic [NUM_W-1:0]   wabs_reg   [NCHAN];
    logic [COLOR_W-1:0] drive_reg  [NCHAN];
    logic [DUR_W-1:0]   dur_reg;
    logic [DUR_W-1:0]   hold_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QM_W-1:0]    qm_reg;

    logic [COLOR_W-1:0] red_out_reg;
    logic [COLOR_W-1:0] green_out_reg;
    logic [COLOR_W-1:0] blue_out_reg;
    logic [DUR_W-1:0]   hold_out_reg;
    logic               last_out_reg;

    logic               cfg_wr;
    logic               in_acc;
    logic               load;
    logic [STEPS_W-1:0] steps_clamped;
    logic [COLOR_W-1:0] targets[NCHAN];
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_numer;
    logic [NUM_W-1:0]   div_quot;
    logic [Q_W-1:0]     q_val;
    logic [Q_W:0]       v_signed;
    logic [COLOR_W-1:0] v_clamped;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_POLARITY[ADDR_W-1]);
    assign prdata = (paddr[ADDR_W-1] == REG_POLARITY[ADDR_W-1])
                  ? {{(DATA_W-1){1'b0}}, anode_reg} : '0;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign load     = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign targets[0] = target_red;
    assign targets[1] = target_green;
    assign targets[2] = target_blue;

    always_comb
    begin
        if (step_count == '0)
            steps_clamped = STEPS_W'(1);
        else if (step_count > STEPS_W'(MAX_STEPS))
            steps_clamped = STEPS_W'(MAX_STEPS);
        else
            steps_clamped = step_count;
    end

    assign div_start = (state_reg == S_DSTART);
    assign div_numer = (sub_reg == SUB_HOLD) ? dur_reg
                     : NUM_W'(absdiff_reg[sub_reg]) * NUM_W'(PCT);

    rlfg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (steps_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign q_val = qm_reg[RECIP_SH +: Q_W];

    always_comb
    begin
        if (neg_reg[chan_reg])
            v_signed = {{(Q_W+1-COLOR_W){1'b0}}, tgt_reg[chan_reg]} + {1'b0, q_val};
        else
            v_signed = {{(Q_W+1-COLOR_W){1'b0}}, tgt_reg[chan_reg]} - {1'b0, q_val};
        if (v_signed[Q_W])
            v_clamped = '0;
        else if (v_signed[Q_W-1:0] > {{(Q_W-COLOR_W){1'b0}}, COLOR_MAX})
            v_clamped = COLOR_MAX;
        else
            v_clamped = v_signed[COLOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sub_reg       <= '0;
            chan_reg      <= '0;
            idx_reg       <= '0;
            anode_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NCHAN; c++)
            begin
                cur_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
                anode_reg <= pwdata[0];

            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sub_reg   <= SUB_RED;
                        state_reg <= S_DSTART;
                    end
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (sub_reg == SUB_HOLD)
                        begin
                            idx_reg   <= STEP_W'(steps_reg - STEPS_W'(1));
                            chan_reg  <= SUB_RED;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            sub_reg   <= sub_reg + 1'b1;
                            state_reg <= S_DSTART;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_RECIP;
                end
                S_RECIP:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (chan_reg == SUB_BLUE)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        chan_reg  <= chan_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_EMIT:
                begin
                    if (load)
                    begin
                        if (idx_reg == '0)
                        begin
                            for (int c = 0; c < NCHAN; c++)
                            begin
                                cur_reg[c] <= tgt_reg[c];
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            chan_reg  <= SUB_RED;
                            state_reg <= S_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            steps_reg <= steps_clamped;
            dur_reg   <= duration_ms;
            for (int c = 0; c < NCHAN; c++)
            begin
                tgt_reg[c] <= targets[c];
                neg_reg[c] <= (targets[c] < cur_reg[c]);
                absdiff_reg[c] <= (targets[c] < cur_reg[c]) ? (cur_reg[c] - targets[c])
                                                            : (targets[c] - cur_reg[c]);
            end
        end

        if ((state_reg == S_DWAIT) && div_done)
        begin
            if (sub_reg == SUB_HOLD)
                hold_reg <= div_quot;
            else
                wabs_reg[sub_reg] <= div_quot;
        end

        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(wabs_reg[chan_reg]);

        if (state_reg == S_RECIP)
            qm_reg <= QM_W'(prod_reg) * QM_W'(RECIP_100);

        if (state_reg == S_FIN)
            drive_reg[chan_reg] <= anode_reg ? ~v_clamped : v_clamped;

        if (load)
        begin
            red_out_reg   <= drive_reg[0];
            green_out_reg <= drive_reg[1];
            blue_out_reg  <= drive_reg[2];
            hold_out_reg  <= hold_reg;
            last_out_reg  <= (idx_reg == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_drive   = red_out_reg;
    assign green_drive = green_out_reg;
    assign blue_drive  = blue_out_reg;
    assign hold_ms     = hold_out_reg;
    assign last_step   = last_out_reg;

    `RLFG_ASSERT_NEXT(a_last_to_idle, load && (idx_reg == '0), state_reg == S_IDLE,
        "Fade did not return to idle after its last step.")
    `RLFG_ASSERT_NOW(a_done_in_wait, div_done, state_reg == S_DWAIT,
        "Divider finished outside the wait state.")
    `RLFG_ASSERT_NEXT(a_accept_starts_div, in_acc,
        (state_reg == S_DSTART) && (sub_reg == SUB_RED),
        "Accepted request did not start the red division.")
    `RLFG_ASSERT_NOW(a_index_in_range, (state_reg == S_MUL) || (state_reg == S_EMIT),
        STEPS_W'(idx_reg) < steps_reg,
        "Step index reached the step count.")

endmodule
